/* rtl/sfpc_pkg.sv */
// Shared types, constants and the frame pre-classification for the subnet filter.
`default_nettype none

package sfpc_pkg;

  localparam int unsigned SOURCE_RULES_DEF = 32;
  localparam int unsigned DEST_RULES_DEF   = 32;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP     = 8'd1;

  localparam logic [5:0] ETH_HDR_LEN   = 6'd14;
  localparam logic [5:0] MIN_IPV4_LEN  = 6'd34;
  localparam logic [5:0] POS_ETYPE_HI  = 6'd12;
  localparam logic [5:0] POS_ETYPE_LO  = 6'd13;
  localparam logic [5:0] POS_PROTO     = 6'd23;
  localparam logic [5:0] POS_SRC_FIRST = 6'd26;
  localparam logic [5:0] POS_SRC_LAST  = 6'd29;
  localparam logic [5:0] POS_DST_FIRST = 6'd30;
  localparam logic [5:0] POS_DST_LAST  = 6'd33;

  typedef enum logic [1:0] {
    OP_FRAME    = 2'd0,
    OP_SRC_RULE = 2'd1,
    OP_DST_RULE = 2'd2
  } op_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SRC_COUNT    = 4'd0,
    REG_DST_COUNT    = 4'd1,
    REG_CONFIG_VALID = 4'd2,
    REG_SOCKET       = 4'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    RSN_REDIRECTED = 3'd0,
    RSN_MALFORMED  = 3'd1,
    RSN_ARP        = 3'd2,
    RSN_ICMP       = 3'd3,
    RSN_NO_CONFIG  = 3'd4,
    RSN_NO_MATCH   = 3'd5,
    RSN_NO_SOCKET  = 3'd6
  } reason_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_WALK,
    ST_DRAIN,
    ST_VERDICT
  } state_t;

  typedef struct packed {
    logic accept;
    logic walk_start;
    logic walk_step;
    logic result_load;
    logic use_match;
  } dp_cmd_t;

  typedef struct packed {
    logic frame_last;
    logic need_match;
    logic walk_empty;
    logic walk_last;
  } dp_sts_t;

  typedef struct packed {
    logic [31:0] network;
    logic [31:0] mask;
  } rule_t;

  typedef struct packed {
    logic    need_match;
    reason_t reason;
  } prelim_t;

  // Verdict for everything that does not need the rule tables.
  function automatic prelim_t prelim_verdict(input logic [5:0]  length,
                                             input logic [15:0] ether_type,
                                             input logic [7:0]  protocol,
                                             input logic        cfg_valid);
    prelim_t res;
    res.need_match = 1'b0;
    res.reason     = RSN_MALFORMED;
    priority if (length < ETH_HDR_LEN) begin
      res.reason = RSN_MALFORMED;
    end else if (ether_type == ETHERTYPE_ARP) begin
      res.reason = RSN_ARP;
    end else if (ether_type != ETHERTYPE_IPV4 || length < MIN_IPV4_LEN) begin
      res.reason = RSN_MALFORMED;
    end else if (protocol == PROTO_ICMP) begin
      res.reason = RSN_ICMP;
    end else if (!cfg_valid) begin
      res.reason = RSN_NO_CONFIG;
    end else begin
      res.need_match = 1'b1;
      res.reason     = RSN_REDIRECTED;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/sfpc_ifs.sv */
// Channel interfaces of the subnet filter: input words, verdicts and register writes.
`default_nettype none

interface sfpc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [4:0]  rule_index;
  logic [31:0] rule_network;
  logic [31:0] rule_mask;

  modport source (output valid, operation, data_byte, last_byte, rule_index,
                  rule_network, rule_mask, input ready);
  modport sink   (input valid, operation, data_byte, last_byte, rule_index,
                  rule_network, rule_mask, output ready);
endinterface

interface sfpc_out_if;
  logic       valid;
  logic       ready;
  logic       redirect;
  logic [2:0] reason;

  modport source (output valid, redirect, reason, input ready);
  modport sink   (input valid, redirect, reason, output ready);
endinterface

interface sfpc_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] reg_index;
  logic [7:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

/* rtl/subnet_filter_packet_classifier.sv */
// Top level of the IPv4 source/destination subnet filter.
`default_nettype none

// Each input word is either one Ethernet frame byte or a source/destination rule
// write. The word carrying the last byte of a frame is followed by a classification
// state (ST_CLASSIFY). When the frame is IPv4, not ICMP, and configuration
// is valid, the verdict also needs the rule tables: with both rule counts zero the
// controller goes on straight to ST_VERDICT, otherwise the source and destination
// rule memories are walked side by side at one entry per cycle in ST_WALK, over
// max(used source, used destination rules) entries, then ST_DRAIN and ST_VERDICT.
// Used rules are the programmed counts limited to the table sizes. The verdict sits
// in an output register; new words are taken while it waits only if it leaves in
// the same cycle. Register writes are always accepted and must only be issued while
// no frame verdict is outstanding. Rule entries read before being written give an
// undefined match result.
module subnet_filter_packet_classifier import sfpc_pkg::*; #(
  parameter int unsigned SOURCE_RULES      = SOURCE_RULES_DEF,
  parameter int unsigned DESTINATION_RULES = DEST_RULES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  sfpc_in_if.sink           in_chan,
  sfpc_out_if.source        out_chan,
  sfpc_cfg_if.sink          cfg_chan
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    cfg_write;

  assign cfg_chan.ready = 1'b1;
  assign cfg_write      = cfg_chan.valid && cfg_chan.ready;

  sfpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sfpc_datapath #(
    .SOURCE_RULES      (SOURCE_RULES),
    .DESTINATION_RULES (DESTINATION_RULES)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_chan.operation),
    .in_data_byte    (in_chan.data_byte),
    .in_last_byte    (in_chan.last_byte),
    .in_rule_index   (in_chan.rule_index),
    .in_rule_network (in_chan.rule_network),
    .in_rule_mask    (in_chan.rule_mask),
    .cfg_write       (cfg_write),
    .cfg_reg_index   (cfg_chan.reg_index),
    .cfg_wdata       (cfg_chan.wdata),
    .out_redirect    (out_chan.redirect),
    .out_reason      (out_chan.reason)
  );

endmodule

`default_nettype wire

/* rtl/sfpc_datapath.sv */
// Datapath: frame field capture, configuration registers, rule memories and match logic.
`default_nettype none

module sfpc_datapath import sfpc_pkg::*; #(
  parameter int unsigned SOURCE_RULES      = SOURCE_RULES_DEF,
  parameter int unsigned DESTINATION_RULES = DEST_RULES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  input  logic [1:0]            in_operation,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_last_byte,
  input  logic [4:0]            in_rule_index,
  input  logic [31:0]           in_rule_network,
  input  logic [31:0]           in_rule_mask,
  input  logic                  cfg_write,
  input  logic [CFG_ADDR_W-1:0] cfg_reg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_redirect,
  output logic [2:0]            out_reason
);

  localparam int unsigned MAX_RULES =
    (SOURCE_RULES > DESTINATION_RULES) ? SOURCE_RULES : DESTINATION_RULES;
  localparam int unsigned CNT_W  = $clog2(MAX_RULES + 1);
  localparam int unsigned SRC_AW = (SOURCE_RULES > 1) ? $clog2(SOURCE_RULES) : 1;
  localparam int unsigned DST_AW = (DESTINATION_RULES > 1) ? $clog2(DESTINATION_RULES) : 1;

  // Configuration registers.
  logic [5:0] src_num_r;
  logic [5:0] dst_num_r;
  logic       cfg_valid_r;
  logic       socket_r;

  // Frame state.
  logic [5:0]  pos_r,   pos_nxt;
  logic [15:0] etype_r, etype_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] saddr_r, saddr_nxt;
  logic [31:0] daddr_r, daddr_nxt;
  logic [5:0]  length;

  // Rule walk.
  rule_t            src_mem [SOURCE_RULES];
  rule_t            dst_mem [DESTINATION_RULES];
  rule_t            src_rd_r;
  rule_t            dst_rd_r;
  logic             src_live_r;
  logic             dst_live_r;
  logic             src_hit_r;
  logic             dst_hit_r;
  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] src_used;
  logic [CNT_W-1:0] dst_used;
  logic [CNT_W-1:0] walk_len;
  logic             src_match;
  logic             dst_match;
  logic             frame_word;
  logic             src_wr;
  logic             dst_wr;

  // Verdict register.
  logic    redirect_r;
  reason_t reason_r;
  prelim_t prelim;

  assign frame_word = cmd.accept && (in_operation == OP_FRAME);
  assign src_wr = cmd.accept && (in_operation == OP_SRC_RULE)
                  && (32'(in_rule_index) < SOURCE_RULES);
  assign dst_wr = cmd.accept && (in_operation == OP_DST_RULE)
                  && (32'(in_rule_index) < DESTINATION_RULES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_num_r   <= '0;
      dst_num_r   <= '0;
      cfg_valid_r <= 1'b0;
      socket_r    <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_reg_index)
        REG_SRC_COUNT:    src_num_r   <= cfg_wdata[5:0];
        REG_DST_COUNT:    dst_num_r   <= cfg_wdata[5:0];
        REG_CONFIG_VALID: cfg_valid_r <= cfg_wdata[0];
        REG_SOCKET:       socket_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign length = (pos_r < MIN_IPV4_LEN) ? pos_r + 6'd1 : MIN_IPV4_LEN;

  // Header fields are shifted in at fixed byte positions; the header length is not checked.
  always_comb begin
    pos_nxt   = pos_r;
    etype_nxt = etype_r;
    proto_nxt = proto_r;
    saddr_nxt = saddr_r;
    daddr_nxt = daddr_r;
    if (cmd.result_load) begin
      pos_nxt   = '0;
      etype_nxt = '0;
      proto_nxt = '0;
      saddr_nxt = '0;
      daddr_nxt = '0;
    end else if (frame_word) begin
      pos_nxt = length;
      priority if (pos_r == POS_ETYPE_HI || pos_r == POS_ETYPE_LO) begin
        etype_nxt = {etype_r[7:0], in_data_byte};
      end else if (pos_r == POS_PROTO) begin
        proto_nxt = in_data_byte;
      end else if (pos_r >= POS_SRC_FIRST && pos_r <= POS_SRC_LAST) begin
        saddr_nxt = {saddr_r[23:0], in_data_byte};
      end else if (pos_r >= POS_DST_FIRST && pos_r <= POS_DST_LAST) begin
        daddr_nxt = {daddr_r[23:0], in_data_byte};
      end else begin
        etype_nxt = etype_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      etype_r <= '0;
      proto_r <= '0;
      saddr_r <= '0;
      daddr_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      etype_r <= etype_nxt;
      proto_r <= proto_nxt;
      saddr_r <= saddr_nxt;
      daddr_r <= daddr_nxt;
    end
  end

  // A rule count above the table size behaves as the table size.
  assign src_used = (32'(src_num_r) > SOURCE_RULES) ? CNT_W'(SOURCE_RULES)
                                                    : CNT_W'(src_num_r);
  assign dst_used = (32'(dst_num_r) > DESTINATION_RULES) ? CNT_W'(DESTINATION_RULES)
                                                         : CNT_W'(dst_num_r);
  assign walk_len = (src_used > dst_used) ? src_used : dst_used;

  // Both tables are walked side by side, one entry of each per cycle.
  always_ff @(posedge clk) begin
    if (src_wr) begin
      src_mem[SRC_AW'(in_rule_index)] <= '{network: in_rule_network, mask: in_rule_mask};
    end
    src_rd_r <= src_mem[idx_r[SRC_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (dst_wr) begin
      dst_mem[DST_AW'(in_rule_index)] <= '{network: in_rule_network, mask: in_rule_mask};
    end
    dst_rd_r <= dst_mem[idx_r[DST_AW-1:0]];
  end

  assign src_match = (saddr_r & src_rd_r.mask) == (src_rd_r.network & src_rd_r.mask);
  assign dst_match = (daddr_r & dst_rd_r.mask) == (dst_rd_r.network & dst_rd_r.mask);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      src_live_r <= 1'b0;
      dst_live_r <= 1'b0;
      src_hit_r  <= 1'b0;
      dst_hit_r  <= 1'b0;
    end else begin
      src_live_r <= cmd.walk_step && (idx_r < src_used);
      dst_live_r <= cmd.walk_step && (idx_r < dst_used);
      if (cmd.walk_start) begin
        idx_r     <= '0;
        src_hit_r <= (src_used == '0);
        dst_hit_r <= (dst_used == '0);
      end else begin
        if (cmd.walk_step) begin
          idx_r <= idx_r + CNT_W'(1);
        end
        if (src_live_r && src_match) begin
          src_hit_r <= 1'b1;
        end
        if (dst_live_r && dst_match) begin
          dst_hit_r <= 1'b1;
        end
      end
    end
  end

  assign prelim = prelim_verdict(pos_r, etype_r, proto_r, cfg_valid_r);

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      if (cmd.use_match) begin
        priority if (!(src_hit_r && dst_hit_r)) begin
          redirect_r <= 1'b0;
          reason_r   <= RSN_NO_MATCH;
        end else if (!socket_r) begin
          redirect_r <= 1'b0;
          reason_r   <= RSN_NO_SOCKET;
        end else begin
          redirect_r <= 1'b1;
          reason_r   <= RSN_REDIRECTED;
        end
      end else begin
        redirect_r <= 1'b0;
        reason_r   <= prelim.reason;
      end
    end
  end

  assign out_redirect = redirect_r;
  assign out_reason   = reason_r;

  assign sts.frame_last = (in_operation == OP_FRAME) && in_last_byte;
  assign sts.need_match = prelim.need_match;
  assign sts.walk_empty = (walk_len == '0);
  assign sts.walk_last  = (idx_r == walk_len - CNT_W'(1));

endmodule

`default_nettype wire

/* rtl/sfpc_ctrl.sv */
// Controller: state machine that sequences frame capture, rule walk and verdict hand-off.
`default_nettype none

module sfpc_ctrl import sfpc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  // A word is taken only when the verdict slot is empty or is being emptied this cycle.
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && sts.frame_last) begin
          state_nxt = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        priority if (!sts.need_match) begin
          state_nxt = ST_IDLE;
        end else if (sts.walk_empty) begin
          state_nxt = ST_VERDICT;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (sts.walk_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN:   state_nxt = ST_VERDICT;
      ST_VERDICT: state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.accept = accept;
    unique case (state_r)
      ST_CLASSIFY: begin
        cmd.walk_start  = sts.need_match;
        cmd.result_load = !sts.need_match;
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
      end
      ST_VERDICT: begin
        cmd.result_load = 1'b1;
        cmd.use_match   = 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = cmd.result_load ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_verdict_delivered: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_VERDICT) |=> (state_r == ST_IDLE && out_valid_r))
    else $error("rule walk verdict not presented");

  a_short_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLASSIFY && !sts.need_match) |=> out_valid_r)
    else $error("direct verdict not presented");

  a_verdict_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_CLASSIFY || $past(state_r) == ST_VERDICT))
    else $error("verdict appeared without a classification");

  a_slot_empty_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK || state_r == ST_DRAIN) |-> !out_valid_r)
    else $error("verdict slot occupied during rule walk");

endmodule

`default_nettype wire
